### hdl/tswc_pkg.sv
`default_nettype none

package tswc_pkg;

    // coordinate and register widths
    localparam int COORD_BITS     = 16;
    localparam int ROW_LENGTH_W   = 11;
    localparam int COS_W          = 16;
    localparam int THR_SQ_W       = 2 * COS_W;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 1;
    localparam int SQ_W           = 10;

    // up component squared is scaled by 2^30 before the compare
    localparam int UP_SHIFT       = 30;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COS_THRESHOLD = 1'd1;

    // register reset values
    localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RESET    = 11'd2;
    localparam logic [COS_W-1:0]        COS_THRESHOLD_RESET = 16'd23170;
    localparam int                      MIN_ROW_LENGTH      = 2;

    // default sizes
    localparam int MAX_ROW_LENGTH_DEF = 1024;
    localparam int MAX_ROWS_DEF       = 1024;

    // square queue and result buffer
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int RES_DEPTH   = 8;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_CNT_W   = RES_PTR_W + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] vertex_z;
        logic                         grid_start;
    } t_vertex_in;

    typedef struct packed {
        logic [SQ_W-1:0] square_row;
        logic [SQ_W-1:0] square_col;
        logic            walkable;
    } t_result;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_vtx;

    // one completed square: far-left, near-left, near-right (cur), far-right
    typedef struct packed {
        t_vtx            fl;
        t_vtx            nl;
        t_vtx            cur;
        t_vtx            fr;
        logic [SQ_W-1:0] row;
        logic [SQ_W-1:0] col;
    } t_square;

endpackage

`default_nettype wire

### hdl/tswc_ram.sv
`default_nettype none

module tswc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/tswc_queue.sv
`default_nettype none

module tswc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tswc_pkg::t_square i_push_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output tswc_pkg::t_square      o_head
);
    import tswc_pkg::*;

    localparam int CW = Q_PTR_W + 1;

    t_square            r_data [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [CW-1:0]      r_cnt;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_data[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    // entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/tswc_front.sv
`default_nettype none

module tswc_front #(
    parameter int MAX_ROW_LENGTH = tswc_pkg::MAX_ROW_LENGTH_DEF,
    parameter int MAX_ROWS       = tswc_pkg::MAX_ROWS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire tswc_pkg::t_vertex_in               i_in_item,
    input  wire logic [tswc_pkg::ROW_LENGTH_W-1:0]  i_row_length,
    output logic                                    o_q_push,
    output tswc_pkg::t_square                       o_q_data,
    input  wire logic                               i_q_full
);
    import tswc_pkg::*;

    localparam int LENW = $clog2(MAX_ROW_LENGTH + 1);
    localparam int CW   = (LENW > ROW_LENGTH_W) ? LENW : ROW_LENGTH_W;
    localparam int AW   = $clog2(MAX_ROW_LENGTH);
    localparam int RCW  = $clog2(MAX_ROWS);
    localparam int RCW1 = RCW + 1;
    localparam int XW   = (RCW > SQ_W) ? RCW : SQ_W;
    localparam int YW   = (AW > SQ_W) ? AW : SQ_W;
    localparam int VW   = $bits(t_vtx);

    typedef enum logic {
        S_TAKE,
        S_READ
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_col;
    logic [RCW-1:0]   r_row;
    logic             r_emit;
    logic [SQ_W-1:0]  r_sq_row;
    logic [SQ_W-1:0]  r_sq_col;
    t_vtx             r_cur;
    t_vtx             r_fl;
    t_vtx             r_nl;

    logic             w_accept;
    t_vtx             w_vtx;
    logic [CW-1:0]    w_len_raw;
    logic [CW-1:0]    w_len;
    logic [AW-1:0]    w_col_now;
    logic [RCW-1:0]   w_row_now;
    logic [CW-1:0]    w_col_inc;
    logic [RCW1-1:0]  w_row_inc;
    logic [XW-1:0]    w_sq_row;
    logic [YW-1:0]    w_sq_col;
    logic [VW-1:0]    w_rd;

    assign o_in_ready = (r_state == S_TAKE) && !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_vtx.x = i_in_item.vertex_x;
    assign w_vtx.y = i_in_item.vertex_y;
    assign w_vtx.z = i_in_item.vertex_z;

    // effective row length, held to the supported range
    assign w_len_raw = CW'(i_row_length);
    always_comb begin
        priority if (w_len_raw < CW'(MIN_ROW_LENGTH)) begin
            w_len = CW'(MIN_ROW_LENGTH);
        end else if (w_len_raw > CW'(MAX_ROW_LENGTH)) begin
            w_len = CW'(MAX_ROW_LENGTH);
        end else begin
            w_len = w_len_raw;
        end
    end

    // position of this vertex, grid start restarts both counters
    assign w_col_now = i_in_item.grid_start ? '0 : r_col;
    assign w_row_now = i_in_item.grid_start ? '0 : r_row;
    assign w_col_inc = CW'(w_col_now) + CW'(1);
    assign w_row_inc = RCW1'(w_row_now) + RCW1'(1);
    assign w_sq_row  = XW'(w_row_now) - XW'(1);
    assign w_sq_col  = YW'(w_col_now) - YW'(1);

    // previous row line buffer, read and overwritten at the same column
    tswc_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_col_now),
        .i_wdata (w_vtx),
        .i_raddr (w_col_now),
        .o_rdata (w_rd)
    );

    // square handed to the queue once the far-right corner is read
    assign o_q_push     = (r_state == S_READ) && r_emit;
    assign o_q_data.fl  = r_fl;
    assign o_q_data.nl  = r_nl;
    assign o_q_data.cur = r_cur;
    assign o_q_data.fr  = t_vtx'(w_rd);
    assign o_q_data.row = r_sq_row;
    assign o_q_data.col = r_sq_col;

    // take a vertex, then read the line buffer and shift the left corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_col   <= '0;
            r_row   <= '0;
            r_emit  <= 1'b0;
        end else begin
            unique case (r_state)
                S_TAKE: begin
                    if (w_accept) begin
                        r_cur    <= w_vtx;
                        r_emit   <= (w_col_now != '0) && (w_row_now != '0);
                        r_sq_row <= w_sq_row[SQ_W-1:0];
                        r_sq_col <= w_sq_col[SQ_W-1:0];
                        if (w_col_inc >= w_len) begin
                            r_col <= '0;
                            if (w_row_inc >= RCW1'(MAX_ROWS)) begin
                                r_row <= '0;
                            end else begin
                                r_row <= w_row_inc[RCW-1:0];
                            end
                        end else begin
                            r_col <= w_col_inc[AW-1:0];
                            r_row <= w_row_now;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_fl    <= t_vtx'(w_rd);
                    r_nl    <= r_cur;
                    r_state <= S_TAKE;
                end
                default: begin
                    r_state <= S_TAKE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/tswc_tri.sv
`default_nettype none

module tswc_tri (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_vld,
    input  wire tswc_pkg::t_vtx                 i_p0,
    input  wire tswc_pkg::t_vtx                 i_p1,
    input  wire tswc_pkg::t_vtx                 i_p2,
    input  wire logic [tswc_pkg::THR_SQ_W-1:0]  i_thr_sq,
    output logic                                o_vld,
    output logic                                o_pass
);
    import tswc_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int NW  = PW + 1;
    localparam int SW  = 2 * (NW - 1);
    localparam int LW  = SW + 2;
    localparam int HW  = (LW + 1) / 2;
    localparam int GW  = LW - HW;
    localparam int RW  = THR_SQ_W + LW;
    localparam int LAT = 7;

    logic [LAT-1:0] r_vld;

    // stage 1: edge vectors a = p2 - p0, b = p0 - p1
    logic signed [DW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    // stage 2: cross product terms
    logic signed [PW-1:0] r_m1, r_m2, r_m3, r_m4, r_m5, r_m6;
    // stage 3: normal
    logic signed [NW-1:0] r_nx, r_ny, r_nz;
    // stage 4: squared components and flags
    logic signed [2*NW-1:0] w_sqx, w_sqy, w_sqz;
    logic [SW-1:0] r_sx, r_sy4, r_sz;
    logic          r_neg4, r_deg4;
    // stage 5: squared length
    logic [LW-1:0] r_len2;
    logic [SW-1:0] r_sy5;
    logic          r_neg5, r_deg5;
    // stage 6: threshold squared times length, in two halves
    logic [THR_SQ_W+HW-1:0] r_rlo;
    logic [THR_SQ_W+GW-1:0] r_rhi;
    logic [SW-1:0]          r_sy6;
    logic                   r_neg6, r_deg6;
    // stage 7: compare
    logic [RW-1:0] w_rhs;
    logic [RW-1:0] w_lhs;
    logic          r_pass;

    assign w_sqx = r_nx * r_nx;
    assign w_sqy = r_ny * r_ny;
    assign w_sqz = r_nz * r_nz;
    assign w_rhs = RW'(r_rlo) + (RW'(r_rhi) << HW);
    assign w_lhs = RW'(r_sy6) << UP_SHIFT;

    // valid shift through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_vld};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_ax <= DW'(i_p2.x) - DW'(i_p0.x);
        r_ay <= DW'(i_p2.y) - DW'(i_p0.y);
        r_az <= DW'(i_p2.z) - DW'(i_p0.z);
        r_bx <= DW'(i_p0.x) - DW'(i_p1.x);
        r_by <= DW'(i_p0.y) - DW'(i_p1.y);
        r_bz <= DW'(i_p0.z) - DW'(i_p1.z);

        r_m1 <= r_ay * r_bz;
        r_m2 <= r_az * r_by;
        r_m3 <= r_az * r_bx;
        r_m4 <= r_ax * r_bz;
        r_m5 <= r_ax * r_by;
        r_m6 <= r_ay * r_bx;

        r_nx <= NW'(r_m1) - NW'(r_m2);
        r_ny <= NW'(r_m3) - NW'(r_m4);
        r_nz <= NW'(r_m5) - NW'(r_m6);

        r_sx   <= w_sqx[SW-1:0];
        r_sy4  <= w_sqy[SW-1:0];
        r_sz   <= w_sqz[SW-1:0];
        r_neg4 <= r_ny[NW-1];
        r_deg4 <= (r_nx == '0) && (r_ny == '0) && (r_nz == '0);

        r_len2 <= LW'(r_sx) + LW'(r_sy4) + LW'(r_sz);
        r_sy5  <= r_sy4;
        r_neg5 <= r_neg4;
        r_deg5 <= r_deg4;

        r_rlo  <= i_thr_sq * r_len2[HW-1:0];
        r_rhi  <= i_thr_sq * r_len2[LW-1:HW];
        r_sy6  <= r_sy5;
        r_neg6 <= r_neg5;
        r_deg6 <= r_deg5;

        r_pass <= !r_neg6 && !r_deg6 && (w_lhs >= w_rhs);
    end

    assign o_vld  = r_vld[LAT-1];
    assign o_pass = r_pass;

endmodule

`default_nettype wire

### hdl/tswc_back.sv
`default_nettype none

module tswc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_empty,
    input  wire tswc_pkg::t_square          i_q_head,
    output logic                            o_q_pop,
    input  wire logic [tswc_pkg::COS_W-1:0] i_cos_threshold,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output tswc_pkg::t_result               o_out_item
);
    import tswc_pkg::*;

    logic [THR_SQ_W-1:0]  r_thr_sq;
    logic [RES_PTR_W-1:0] r_lp;
    logic [RES_PTR_W-1:0] r_dp;
    logic [RES_PTR_W-1:0] r_rp;
    logic [RES_CNT_W-1:0] r_used;
    logic [RES_CNT_W-1:0] r_avail;
    logic [SQ_W-1:0]      r_row  [RES_DEPTH];
    logic [SQ_W-1:0]      r_col  [RES_DEPTH];
    logic                 r_walk [RES_DEPTH];

    logic w_launch;
    logic w_pop;
    logic w_vld0, w_vld1;
    logic w_pass0, w_pass1;

    // threshold squared, registered from the threshold register
    always_ff @(posedge i_clk) begin
        r_thr_sq <= i_cos_threshold * i_cos_threshold;
    end

    // launch only when a result slot is reserved for the square
    assign w_launch = !i_q_empty && (r_used != RES_CNT_W'(RES_DEPTH));
    assign o_q_pop  = w_launch;

    // lower-left triangle and upper-right triangle, side by side
    tswc_tri u_tri_near (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_launch),
        .i_p0     (i_q_head.fl),
        .i_p1     (i_q_head.nl),
        .i_p2     (i_q_head.cur),
        .i_thr_sq (r_thr_sq),
        .o_vld    (w_vld0),
        .o_pass   (w_pass0)
    );

    tswc_tri u_tri_far (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_launch),
        .i_p0     (i_q_head.fl),
        .i_p1     (i_q_head.cur),
        .i_p2     (i_q_head.fr),
        .i_thr_sq (r_thr_sq),
        .o_vld    (w_vld1),
        .o_pass   (w_pass1)
    );

    // result buffer head
    assign o_out_valid           = (r_avail != '0);
    assign o_out_item.square_row = r_row[r_rp];
    assign o_out_item.square_col = r_col[r_rp];
    assign o_out_item.walkable   = r_walk[r_rp];
    assign w_pop                 = o_out_valid && i_out_ready;

    // slot bookkeeping: reserved at launch, filled at finish, freed at output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp    <= '0;
            r_dp    <= '0;
            r_rp    <= '0;
            r_used  <= '0;
            r_avail <= '0;
        end else begin
            if (w_launch) begin
                r_lp <= r_lp + RES_PTR_W'(1);
            end
            if (w_vld0) begin
                r_dp <= r_dp + RES_PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + RES_PTR_W'(1);
            end
            r_used  <= r_used + RES_CNT_W'(w_launch) - RES_CNT_W'(w_pop);
            r_avail <= r_avail + RES_CNT_W'(w_vld0) - RES_CNT_W'(w_pop);
        end
    end

    // slot contents
    always_ff @(posedge i_clk) begin
        if (w_launch) begin
            r_row[r_lp] <= i_q_head.row;
            r_col[r_lp] <= i_q_head.col;
        end
        if (w_vld0) begin
            r_walk[r_dp] <= w_pass0 && w_pass1 && w_vld1;
        end
    end

endmodule

`default_nettype wire

### hdl/terrain_slope_walkability_classifier.sv
// channel   direction  handshake                      payload
// in        input      i_in_valid / o_in_ready        i_in_item   (t_vertex_in)
// out       output     o_out_valid / i_out_ready      o_out_item  (t_result)
// cfg       input      i_cfg_we                       i_cfg_index, i_cfg_data
//
// A vertex is accepted and addresses the line buffer, then the far-right corner is read
// and the left corners shift; the next vertex waits for that and for room in the queue.
// Each square then runs through two 7-stage triangle pipelines in parallel; with nothing
// ahead of it, its result goes from the pipelines into the result buffer and is presented.
// Synchronous reset clears state, counters and config; line buffer and data are not cleared.
// A 2-entry square queue and an 8-entry result buffer let input and output stall apart.
`default_nettype none

module terrain_slope_walkability_classifier #(
    parameter int MAX_ROW_LENGTH = tswc_pkg::MAX_ROW_LENGTH_DEF,
    parameter int MAX_ROWS       = tswc_pkg::MAX_ROWS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tswc_pkg::t_vertex_in              i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tswc_pkg::t_result                      o_out_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [tswc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [tswc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tswc_pkg::*;

    logic [ROW_LENGTH_W-1:0] r_row_length;
    logic [COS_W-1:0]        r_cos_threshold;

    logic    w_q_push;
    logic    w_q_full;
    logic    w_q_pop;
    logic    w_q_empty;
    t_square w_q_in;
    t_square w_q_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length    <= ROW_LENGTH_RESET;
            r_cos_threshold <= COS_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW_LENGTH:    r_row_length    <= i_cfg_data[ROW_LENGTH_W-1:0];
                REG_COS_THRESHOLD: r_cos_threshold <= i_cfg_data[COS_W-1:0];
                default: ;
            endcase
        end
    end

    // vertex intake and line buffer
    tswc_front #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROWS       (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_row_length (r_row_length),
        .o_q_push     (w_q_push),
        .o_q_data     (w_q_in),
        .i_q_full     (w_q_full)
    );

    // squares waiting for the slope test
    tswc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_q_push),
        .i_push_data (w_q_in),
        .o_full      (w_q_full),
        .i_pop       (w_q_pop),
        .o_empty     (w_q_empty),
        .o_head      (w_q_head)
    );

    // slope test and result buffer
    tswc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .i_q_head        (w_q_head),
        .o_q_pop         (w_q_pop),
        .i_cos_threshold (r_cos_threshold),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_item      (o_out_item)
    );

    // no square is pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_push && w_q_full))
        else $error("square queue overflow");

    // no square is taken from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_pop && w_q_empty))
        else $error("square queue underflow");

    // in the cycle after an item is taken the front reads the line buffer and is not ready
    a_read_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item taken during line buffer read");

endmodule

`default_nettype wire
